FILE: design/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg: shared types for barometric sensor compensation
// Payload structs, register indexes and small arithmetic helpers.
// ----------------------------------------------------------------------------
package bsc_pkg;

    typedef struct packed {
        logic [15:0] raw_temperature;
        logic [18:0] raw_pressure;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic [19:0]        pressure_pa;
        logic               divide_error;
    } out_word_t;

    typedef struct packed {
        logic [63:0] cal_a;
        logic [63:0] cal_b;
        logic [31:0] cal_c;
        logic [1:0]  oss;
    } cal_t;

    localparam logic [1:0] REG_CAL_A = 2'd0;
    localparam logic [1:0] REG_CAL_B = 2'd1;
    localparam logic [1:0] REG_CAL_C = 2'd2;
    localparam logic [1:0] REG_OSS   = 2'd3;
    localparam int CFG_IDX_W = 2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // arithmetic right shift of a 32-bit signed value
    function automatic logic signed [31:0] asr32(input logic signed [31:0] x,
                                                  input int k);
        asr32 = x >>> k;
    endfunction

endpackage

FILE: design/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: integer temperature/pressure compensation
// Front takes raw words into a queue; the back engine compensates them.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  in      | in  | in_valid/in_stall  | raw temperature, raw pressure
//  out     | out | out_valid/out_stall| tenths degC, Pa, divide error
//  cfg     | in  | cfg_we             | cfg_index selects calibration reg
//
// Per word, the shared radix-2 32-bit divider runs twice (temperature then
// pressure) alongside 11 sequencing steps. A zero temperature divisor or a
// zero B4 ends a word early with the divide error set.
// The input queue holds four words so the source is held only when the
// queue is full. Reset clears calibration to zero and empties queue and
// output. A stalled output word holds; the engine waits in its last step.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                  cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  bsc_pkg::in_word_t            in_word,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bsc_pkg::out_word_t           out_word
);
    import bsc_pkg::*;

    cal_t     cal_reg;
    logic     q_full, q_ne, q_pop;
    in_word_t q_head;

    // calibration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_A: cal_reg.cal_a <= cfg_data;
                REG_CAL_B: cal_reg.cal_b <= cfg_data;
                REG_CAL_C: cal_reg.cal_c <= cfg_data[31:0];
                REG_OSS:   cal_reg.oss   <= cfg_data[1:0];
                default:   ;
            endcase
        end
    end

    // front: accept words whenever the queue has room
    assign in_stall = q_full;

    bsc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(in_valid && !q_full), .push_word(in_word), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .head(q_head)
    );

    bsc_engine u_engine (
        .clk(clk), .rst_n(rst_n), .cal(cal_reg),
        .item_valid(q_ne), .item(q_head), .item_take(q_pop),
        .valid(out_valid), .stall(out_stall), .result(out_word)
    );
endmodule

FILE: design/bsc_udiv.sv
// ----------------------------------------------------------------------------
// bsc_udiv: radix-2 restoring divider, 32/32 unsigned
// One quotient bit per cycle; start only while idle.
// ----------------------------------------------------------------------------
module bsc_udiv (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        trial     = {r_reg[31:0], q_reg[31]} - {1'b0, d_reg};
        if (start)
        begin
            cnt_next = 6'd32;
            q_next   = dividend;
            r_next   = '0;
            d_next   = divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (!trial[32])
            begin
                r_next = trial;
                q_next = {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[31:0], q_reg[31]};
                q_next = {q_reg[30:0], 1'b0};
            end
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = (cnt_reg != 6'd0);
    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

FILE: design/bsc_queue.sv
// ----------------------------------------------------------------------------
// bsc_queue: small word queue between front and back
// Four entries, flop based.
// ----------------------------------------------------------------------------
module bsc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bsc_pkg::in_word_t push_word,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output bsc_pkg::in_word_t head
);
    import bsc_pkg::*;

    in_word_t          mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_word;
    end

    assign full      = (cnt_reg == QDEPTH[QPTR_W:0]);
    assign not_empty = (cnt_reg != '0);
    assign head      = mem_reg[rp_reg];

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
        else $error("queue pop while empty");
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue push while full");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= QDEPTH)
        else $error("queue count overflow");
endmodule

FILE: design/bsc_engine.sv
// ----------------------------------------------------------------------------
// bsc_engine: compensation sequencer
// Multi-step datapath with one shared divider; one word at a time.
// ----------------------------------------------------------------------------
module bsc_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  bsc_pkg::cal_t      cal,
    input  logic               item_valid,
    input  bsc_pkg::in_word_t  item,
    output logic               item_take,
    output logic               valid,
    input  logic               stall,
    output bsc_pkg::out_word_t result
);
    import bsc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_T1   = 4'd1;
    localparam logic [3:0] S_TDIV = 4'd2;
    localparam logic [3:0] S_B6   = 4'd3;
    localparam logic [3:0] S_P1   = 4'd4;
    localparam logic [3:0] S_P2   = 4'd5;
    localparam logic [3:0] S_P3   = 4'd6;
    localparam logic [3:0] S_PDIV = 4'd7;
    localparam logic [3:0] S_F1   = 4'd8;
    localparam logic [3:0] S_F2   = 4'd9;
    localparam logic [3:0] S_F3   = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_F0   = 4'd12;

    logic [3:0] st_reg;

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [31:0]        ac4, ac5, ac6;
    assign ac1 = 32'(signed'(cal.cal_a[63:48]));
    assign ac2 = 32'(signed'(cal.cal_a[47:32]));
    assign ac3 = 32'(signed'(cal.cal_a[31:16]));
    assign ac4 = {16'd0, cal.cal_a[15:0]};
    assign ac5 = {16'd0, cal.cal_b[63:48]};
    assign ac6 = {16'd0, cal.cal_b[47:32]};
    assign b1  = 32'(signed'(cal.cal_b[31:16]));
    assign b2  = 32'(signed'(cal.cal_b[15:0]));
    assign mc  = 32'(signed'(cal.cal_c[31:16]));
    assign md  = 32'(signed'(cal.cal_c[15:0]));

    logic [15:0]        ut_reg;
    logic [18:0]        up_reg;
    logic signed [31:0] x1_reg, b5_reg, b6_reg, sq_reg;
    logic signed [31:0] m1_reg, m2_reg, m3_reg, m4_reg, b3_reg, p_reg;
    logic [31:0]        b4_reg;
    logic               tneg_reg, big_reg, dv_reg;
    logic               vld_reg;
    out_word_t          res_reg;

    // divider
    logic        div_start, div_busy, div_done;
    logic [31:0] div_n, div_d, div_q;
    bsc_udiv u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_n),
        .divisor(div_d), .busy(div_busy), .done(div_done), .quotient(div_q)
    );

    // combinational helpers
    logic signed [31:0] mcs, x2w, t_val, x3, b3a, b3w, x3b, b4u;
    logic [31:0]        pdiff, b7w, pq_corr;
    logic signed [31:0] tq, pfin;
    logic [31:0]        b4prod;

    assign mcs   = mc <<< 11;
    assign x2w   = x1_reg + md;          // temperature divisor
    assign x3    = m1_reg + m2_reg;
    assign b3a   = (((ac1 <<< 2) + x3) <<< cal.oss);
    assign b3w   = asr32(b3a + 32'sd2, 2);
    assign x3b   = asr32(m3_reg + m4_reg + 32'sd2, 2);
    assign b4u   = x3b + 32'sd32768;
    assign b4prod = ac4 * $unsigned(b4u);
    assign pdiff = 32'(up_reg) - b3_reg;
    assign b7w   = 32'(pdiff * (32'd50000 >> cal.oss));
    assign tq    = tneg_reg ? -$signed(div_q) : $signed(div_q);
    assign pq_corr = big_reg ? (div_q << 1) : div_q;
    assign t_val = asr32(b5_reg + 32'sd8, 4);
    assign pfin  = p_reg + asr32(m1_reg + m2_reg + 32'sd3791, 4);

    always_comb
    begin
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        if (st_reg == S_T1 && x2w != 32'sd0)
        begin
            div_start = 1'b1;
            div_n = mcs[31] ? 32'(-mcs) : 32'(mcs);
            div_d = x2w[31] ? 32'(-x2w) : 32'(x2w);
        end
        else if (st_reg == S_P3 && b4_reg != 32'd0)
        begin
            div_start = 1'b1;
            div_n = b7w[31] ? b7w : (b7w << 1);
            div_d = b4_reg;
        end
    end

    assign item_take = (st_reg == S_IDLE) && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (st_reg == S_OUT && (!vld_reg || !stall))
                vld_reg <= 1'b1;
            else if (!stall)
                vld_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (item_valid) st_reg <= S_F0;
                S_F0:   st_reg <= S_T1;
                S_T1:   st_reg <= (x2w == 32'sd0) ? S_OUT : S_TDIV;
                S_TDIV: if (div_done) st_reg <= S_B6;
                S_B6:   st_reg <= S_P1;
                S_P1:   st_reg <= S_P2;
                S_P2:   st_reg <= S_P3;
                S_P3:   st_reg <= (b4_reg == 32'd0) ? S_OUT : S_PDIV;
                S_PDIV: if (div_done) st_reg <= S_F1;
                S_F1:   st_reg <= S_F2;
                S_F2:   st_reg <= S_F3;
                S_F3:   st_reg <= S_OUT;
                S_OUT:  if (!vld_reg || !stall) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                ut_reg <= item.raw_temperature;
                up_reg <= item.raw_pressure;
            end
            S_F0:
            begin
                x1_reg <= asr32(32'((32'(ut_reg) - ac6) * ac5), 15);
            end
            S_T1:
            begin
                tneg_reg <= mcs[31] ^ x2w[31];
                dv_reg   <= (x2w == 32'sd0);
            end
            S_TDIV:
            begin
                if (div_done)
                    b5_reg <= x1_reg + tq;
            end
            S_B6:
            begin
                b6_reg <= b5_reg - 32'sd4000;
                sq_reg <= asr32(32'((b5_reg - 32'sd4000) * (b5_reg - 32'sd4000)), 12);
            end
            S_P1:
            begin
                m1_reg <= asr32(32'(b2 * sq_reg), 11);
                m2_reg <= asr32(32'(ac2 * b6_reg), 11);
                m3_reg <= asr32(32'(ac3 * b6_reg), 13);
                m4_reg <= asr32(32'(b1 * sq_reg), 16);
            end
            S_P2:
            begin
                b3_reg <= b3w;
                b4_reg <= {15'd0, b4prod[31:15]};
            end
            S_P3:
            begin
                big_reg <= b7w[31];
                dv_reg  <= (b4_reg == 32'd0);
            end
            S_PDIV:
            begin
                if (div_done)
                    p_reg <= $signed(pq_corr);
            end
            S_F1:
            begin
                // (p >> 8) squared
                m1_reg <= 32'(asr32(p_reg, 8) * asr32(p_reg, 8));
            end
            S_F2:
            begin
                m1_reg <= asr32(32'(m1_reg * 32'sd3038), 16);
                m2_reg <= asr32(32'(-32'sd7357 * p_reg), 16);
            end
            S_F3:
            begin
                p_reg <= pfin;
            end
            S_OUT:
            begin
                if (!vld_reg || !stall)
                begin
                    if (dv_reg)
                        res_reg <= '{16'sd0, 20'd0, 1'b1};
                    else
                    begin
                        res_reg.divide_error <= 1'b0;
                        res_reg.temperature_tenths <=
                            (t_val > 32'sd32767) ? 16'sd32767 :
                            (t_val < -32'sd32768) ? 16'sh8000 : t_val[15:0];
                        res_reg.pressure_pa <=
                            (p_reg < 0) ? 20'd0 :
                            (p_reg > 32'sd1048575) ? 20'hFFFFF : p_reg[19:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign valid  = vld_reg;
    assign result = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && stall) |=> $stable(res_reg)) else $error("result changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == S_TDIV || st_reg == S_PDIV))
        else $error("divider done outside divide step");
endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: barometric_sensor_compensation
// Drives raw sensor words through several calibration settings and checks
// every compensated word against an in-bench integer model of the
// compensation math, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module testbench;

    import bsc_pkg::*;

    localparam int QUIET_LIMIT = 20000;  // cycles with no handshake at all
    localparam int DRAIN_WAIT  = 200;    // wait once the queues have drained
    localparam int LONG_HOLD   = 1500;   // one long receiver hold-off
    localparam int HOLD_AT     = 400;    // results seen before that hold-off

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_CAL_A;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_word_t    in_word = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_word_t   out_word;

    // calibration mirror, updated by the write task
    logic [63:0] cal_a = '0;
    logic [63:0] cal_b = '0;
    logic [31:0] cal_c = '0;
    logic [1:0]  oss_cfg = '0;

    in_word_t    raw_words_q[$];      // words still to be offered
    out_word_t   compensated_q[$];    // expected words, oldest first

    int          mismatches = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          quiet_cycles = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          roll;
    bit          hold_done = 1'b0;
    bit          no_idle = 1'b0;      // stretch with no idling on either side
    bit          sender_pause = 1'b0;
    logic        in_taken;
    out_word_t   want;

    barometric_sensor_compensation u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Compensation model: 32-bit two's complement intermediates carried in
    // 64-bit variables and wrapped where the integer algorithm wraps.
    // ------------------------------------------------------------------
    function automatic longint wrap32(longint x);
        return longint'($signed(x[31:0]));
    endfunction

    function automatic out_word_t compensate(in_word_t w);
        longint    ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
        longint    ut, x1, x2, x3, q, b5, b6, sq, b3, t, p;
        bit [63:0] up, u, b4, b7, pu;
        int        oss;
        out_word_t r;
        ac1 = longint'($signed(cal_a[63:48]));
        ac2 = longint'($signed(cal_a[47:32]));
        ac3 = longint'($signed(cal_a[31:16]));
        ac4 = longint'(cal_a[15:0]);
        ac5 = longint'(cal_b[63:48]);
        ac6 = longint'(cal_b[47:32]);
        b1  = longint'($signed(cal_b[31:16]));
        b2  = longint'($signed(cal_b[15:0]));
        mc  = longint'($signed(cal_c[31:16]));
        md  = longint'($signed(cal_c[15:0]));
        oss = int'(oss_cfg);
        ut  = longint'(w.raw_temperature);
        up  = 64'(w.raw_pressure);
        r   = '0;

        // temperature; divisor x1 + md
        x1 = wrap32((ut - ac6) * ac5) >>> 15;
        x2 = wrap32(x1 + md);
        if (x2 == 0)
        begin
            r.divide_error = 1'b1;
            return r;
        end
        q  = (mc * 2048) / x2;          // truncates toward zero
        b5 = wrap32(x1 + q);
        t  = wrap32(b5 + 8) >>> 4;

        // B3, published shift order
        b6 = wrap32(b5 - 4000);
        sq = wrap32(b6 * b6) >>> 12;
        x1 = wrap32(b2 * sq) >>> 11;
        x2 = wrap32(ac2 * b6) >>> 11;
        x3 = wrap32(x1 + x2);
        b3 = wrap32(wrap32(ac1 * 4 + x3) * (longint'(1) << oss));
        b3 = wrap32(b3 + 2) >>> 2;

        // B4 (unsigned); zero is the second divide error
        x1 = wrap32(ac3 * b6) >>> 13;
        x2 = wrap32(b1 * sq) >>> 16;
        x3 = wrap32(x1 + x2 + 2) >>> 2;
        u  = 64'(wrap32(x3 + 32768)) & 64'hFFFF_FFFF;
        b4 = ((64'(ac4) * u) & 64'hFFFF_FFFF) >> 15;
        if (b4 == 0)
        begin
            r.divide_error = 1'b1;
            return r;
        end

        // B7 and raw p; the large-B7 branch divides first
        u  = (up - 64'(b3)) & 64'hFFFF_FFFF;
        b7 = (u * 64'(50000 >> oss)) & 64'hFFFF_FFFF;
        if (b7 < 64'h8000_0000)
            pu = (b7 * 2) / b4;
        else
            pu = ((b7 / b4) * 2) & 64'hFFFF_FFFF;
        p = wrap32(longint'(pu));

        x1 = p >>> 8;
        x1 = wrap32(x1 * x1);
        x1 = wrap32(x1 * 3038) >>> 16;
        x2 = wrap32(-7357 * p) >>> 16;
        p  = wrap32(p + (wrap32(x1 + x2 + 3791) >>> 4));

        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        if (p < 0)
            p = 0;
        if (p > 1048575)
            p = 1048575;
        r.temperature_tenths = t[15:0];
        r.pressure_pa        = p[19:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Random gaps: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    task automatic report_mismatch(string what, longint got, longint exp_val);
        $display("MISMATCH word %0d %s: got %0d expected %0d",
                 words_out, what, got, exp_val);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued raw words; the word held under stall stays put.
    // The expectation is formed at acceptance with the mirrored calibration,
    // which only changes while nothing is in flight.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            in_taken = in_valid && !in_stall;
            if (in_taken)
            begin
                compensated_q.push_back(compensate(in_word));
                words_in++;
            end
            if (in_valid && !in_taken)
                ;                                  // hold word under stall
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (raw_words_q.size() > 0 && !sender_pause)
            begin
                in_word  <= raw_words_q.pop_front();
                in_valid <= 1'b1;
                send_gap <= gap_len();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted word, then picks the next stall.
    // Once HOLD_AT words have arrived it applies the long hold-off so the
    // input queue fills and the block stalls its source.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (compensated_q.size() == 0)
                    report_mismatch("unexpected word", longint'(out_word.pressure_pa), 0);
                else
                begin
                    want = compensated_q.pop_front();
                    if (out_word.temperature_tenths !== want.temperature_tenths)
                        report_mismatch("temperature_tenths",
                                        longint'(out_word.temperature_tenths),
                                        longint'(want.temperature_tenths));
                    if (out_word.pressure_pa !== want.pressure_pa)
                        report_mismatch("pressure_pa", longint'(out_word.pressure_pa),
                                        longint'(want.pressure_pa));
                    if (out_word.divide_error !== want.divide_error)
                        report_mismatch("divide_error", longint'(out_word.divide_error),
                                        longint'(want.divide_error));
                end
                words_out++;
            end
            if (!hold_done && words_out >= HOLD_AT)
            begin
                stall_left = LONG_HOLD;
                hold_done  = 1'b1;
            end
            else if (stall_left == 0 && !no_idle)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 95)
                    stall_left = $urandom_range(10, 60);
                else if (roll >= 70)
                    stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // watchdog: no handshake of any kind for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("barometric_sensor_compensation test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic wait_drained();
        while (raw_words_q.size() != 0 || in_valid || compensated_q.size() != 0)
            @(posedge clk);
        // settle before touching the calibration
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // writes all four registers; junk in the unused upper data bits
    task automatic load_calibration(logic [63:0] a, logic [63:0] b,
                                    logic [31:0] c, logic [1:0] o);
        wait_drained();
        cal_a   = a;
        cal_b   = b;
        cal_c   = c;
        oss_cfg = o;
        no_idle = ($urandom_range(0, 3) == 0);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CAL_A;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= REG_CAL_B;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= REG_CAL_C;
        cfg_data  <= {32'($urandom()), c};
        @(posedge clk);
        cfg_index <= REG_OSS;
        cfg_data  <= {30'($urandom()), 32'($urandom()), o};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_raw(logic [15:0] ut, logic [18:0] up);
        in_word_t w;
        w.raw_temperature = ut;
        w.raw_pressure    = up;
        raw_words_q.push_back(w);
    endtask

    // mostly plausible readings for the oversampling in use, some anything
    task automatic queue_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                queue_raw(16'($urandom_range(15000, 40000)),
                          19'($urandom_range(20000, 45000) << oss_cfg));
            else
                queue_raw(16'($urandom()), 19'($urandom()));
        end
    endtask

    function automatic logic [15:0] jitter(logic [15:0] v, int span);
        return v + 16'($urandom_range(0, 2 * span)) - 16'(span);
    endfunction

    // typical calibration of a real part
    localparam logic [63:0] SHEET_A = {16'd408, 16'hFFB8, 16'hC7D1, 16'd32741};
    localparam logic [63:0] SHEET_B = {16'd32757, 16'd23153, 16'd6190, 16'd4};
    localparam logic [31:0] SHEET_C = {16'hDDF9, 16'd2868};

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // all zero: md = 0 and ac5 = 0 make the temperature divisor zero
        load_calibration('0, '0, '0, 2'd0);
        queue_raw(16'd0, 19'd0);
        queue_raw(16'hFFFF, 19'h7FFFF);
        queue_random(6);

        // typical part, lowest oversampling; extremes of both fields
        load_calibration(SHEET_A, SHEET_B, SHEET_C, 2'd0);
        queue_raw(16'd27898, 19'd23843);
        queue_raw(16'd0, 19'd0);
        queue_raw(16'hFFFF, 19'd0);
        queue_raw(16'd0, 19'h7FFFF);
        queue_raw(16'hFFFF, 19'h7FFFF);
        queue_raw(16'h5555, 19'h2AAAA);
        queue_raw(16'hAAAA, 19'h55555);
        queue_random(100);
        // part way through, sender stops until everything in flight is out
        while (raw_words_q.size() > 50)
            @(posedge clk);
        sender_pause = 1'b1;
        while (in_valid || compensated_q.size() != 0)
            @(posedge clk);
        sender_pause = 1'b0;
        queue_random(100);

        // typical part, highest oversampling
        load_calibration(SHEET_A, SHEET_B, SHEET_C, 2'd3);
        queue_raw(16'd27898, 19'd23843 << 3);
        queue_random(180);

        // all ones: extreme coefficients, saturation likely
        load_calibration('1, '1, '1, 2'd3);
        queue_raw(16'd0, 19'd0);
        queue_raw(16'hFFFF, 19'h7FFFF);
        queue_random(100);

        // ac4 = 0: pressure divisor B4 is zero
        load_calibration({SHEET_A[63:16], 16'd0}, SHEET_B, SHEET_C, 2'd1);
        queue_random(50);

        for (int ph = 0; ph < 9; ph++)
        begin
            if (ph % 3 == 2)
                load_calibration({$urandom(), $urandom()}, {$urandom(), $urandom()},
                                 $urandom(), 2'($urandom()));
            else
                load_calibration({jitter(SHEET_A[63:48], 300), jitter(SHEET_A[47:32], 300),
                                  jitter(SHEET_A[31:16], 2000), jitter(SHEET_A[15:0], 2000)},
                                 {jitter(SHEET_B[63:48], 2000), jitter(SHEET_B[47:32], 2000),
                                  jitter(SHEET_B[31:16], 1000), jitter(SHEET_B[15:0], 50)},
                                 {jitter(SHEET_C[31:16], 1000), jitter(SHEET_C[15:0], 500)},
                                 2'(ph));
            queue_random(140);
        end

        while (raw_words_q.size() != 0 || in_valid || compensated_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && compensated_q.size() == 0)
            $display("barometric_sensor_compensation test passed");
        else
            $display("barometric_sensor_compensation test failed");
        $finish;
    end

endmodule
